// ===== rtl/sgt_pkg.sv =====
package sgt_pkg;

  localparam int S_MAX   = 24;
  localparam int M_MAX   = 16;
  localparam int POS_W   = 24;
  localparam int TURN_W  = 16;
  localparam int SPD_W   = 23;
  localparam int TALLY_W = 16;
  localparam int CRED_W  = 8;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 2;
  localparam int OC_W    = 3;
  localparam int FIELD_W = S_MAX + M_MAX;
  localparam int D_W     = 26;
  localparam int X_W     = 36;
  localparam int P_W     = 40;
  localparam int NUM_W   = 55;
  localparam int DEN_W   = 56;
  localparam int QUO_W   = 22;
  localparam int MUL_W   = 32;

  localparam logic [MUL_W-1:0] K_MS_PER_S    = 32'd1000;
  localparam logic [MUL_W-1:0] K_MDEG_PER_MS = 32'd360000000;

  localparam logic [IDX_W-1:0] REG_SINGLE_TURN = 2'd0;
  localparam logic [IDX_W-1:0] REG_MULTI_TURN  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_CREDIT  = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_TPS     = 2'd3;

  localparam logic [OC_W-1:0] OC_UPDATED   = 3'd0;
  localparam logic [OC_W-1:0] OC_RESYNC    = 3'd1;
  localparam logic [OC_W-1:0] OC_READ_FAIL = 3'd2;
  localparam logic [OC_W-1:0] OC_NO_START  = 3'd3;
  localparam logic [OC_W-1:0] OC_TURN_JUMP = 3'd4;
  localparam logic [OC_W-1:0] OC_OVERSPEED = 3'd5;

  typedef struct packed {
    logic              start_bit;
    logic [POS_W-1:0]  pos;
    logic [TURN_W-1:0] turns;
  } dec_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [4:0] clamp_s(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(S_MAX)) return 5'(S_MAX);
    return v;
  endfunction

  function automatic logic [4:0] clamp_m(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(M_MAX)) return 5'(M_MAX);
    return v;
  endfunction

endpackage

// ===== rtl/sgt_decode.sv =====
module sgt_decode import sgt_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [4:0]           s_i,
  input  logic [4:0]           m_i,
  output dec_t                 dec_o
);

  always_comb begin
    logic [5:0]         total;
    logic [5:0]         shift;
    logic [FIELD_W-1:0] wide;
    logic [FIELD_W-1:0] field;
    logic [FIELD_W-1:0] bin;
    logic [FIELD_W-1:0] upper;
    logic [TURN_W-1:0]  mag;
    total = 6'(s_i) + 6'(m_i);
    if ((7'(total) + 7'd1) > 7'(WORD_BITS)) begin
      shift = 6'd0;
    end else begin
      shift = 6'(WORD_BITS - 1) - total;
    end
    wide = FIELD_W'(word_i) >> shift;
    for (int k = 0; k < FIELD_W; k++) begin
      field[k] = wide[k] & ((k + 1) < int'(total));
    end
    // gray to binary: each bit is the parity of itself and all bits above
    for (int k = 0; k < FIELD_W; k++) begin
      bin[k] = ^(field >> k);
    end
    upper = bin >> s_i;
    for (int k = 0; k < POS_W; k++) begin
      dec_o.pos[k] = bin[k] & (k < int'(s_i));
    end
    for (int k = 0; k < TURN_W; k++) begin
      mag[k] = upper[k] & (k < int'(m_i));
    end
    // negative count m maps to -m-1
    dec_o.turns     = word_i[WORD_BITS-2] ? ~mag : mag;
    dec_o.start_bit = word_i[WORD_BITS-1];
  end

endmodule

// ===== rtl/sgt_div.sv =====
module sgt_div import sgt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             run_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] low_q;
  logic [QUO_W-1:0] quo_q;

  logic             sat;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_d;

  // quotient would need more than QUO_W bits
  assign sat   = {(DEN_W - (NUM_W - QUO_W))'(0), req_i.num[NUM_W-1:QUO_W]} >= req_i.den;
  assign trial = {rem_q, low_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= 5'(QUO_W);
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= DEN_W'(req_i.num[NUM_W-1:QUO_W]);
      low_q <= req_i.num[QUO_W-1:0];
      quo_q <= sat ? '1 : '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/ssi_gray_encoder_tracker.sv =====
// Tracks a multiturn absolute encoder read over SSI. Each input beat carries one serial
// word and its millisecond timestamp, with the read-ok flag in tuser; each one yields
// exactly one result beat with the outcome code in tuser and the last accepted position,
// turn count, speed, error total and link status in tdata. For a good word the MUL_A,
// MUL_B and MUL_C states share one 32x32 multiplier for the plausibility and speed
// products, the OVS state does the speed check, then a 22-step restoring divider gives
// the speed quotient, one quotient bit a cycle. A speed that would saturate skips the
// divider steps; zero elapsed time and overspeed leave the OVS state without the
// divider. A failed read, a missing start bit, a resync or a turn jump finishes straight
// from the CHECK state. The input is not ready while an item is in work and is ready
// again once the result is registered; a finished result waits in the output register
// while the next item is taken, whose own result waits in OUT until the waiting one is taken.
module ssi_gray_encoder_tracker import sgt_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,   // raw_word[31:0], time_ms[63:32]
  input  logic [0:0]       s_axis_tuser,   // read_ok[0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // position[23:0], turns[39:24],
                                           // speed_mdeg[62:40], bit_error_total[78:63],
                                           // link_good[79]
  output logic [2:0]       m_axis_tuser    // outcome[2:0]
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_MUL_A  = 4'd3;
  localparam logic [3:0] ST_MUL_B  = 4'd4;
  localparam logic [3:0] ST_MUL_C  = 4'd5;
  localparam logic [3:0] ST_OVS    = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [4:0]        cfg_s_q, cfg_m_q;
  logic [CRED_W-1:0] cfg_cred_q, cfg_tps_q;

  logic [3:0]        state_q, state_d;
  logic              resync_q, resync_d;
  logic [POS_W-1:0]  prev_pos_q, prev_pos_d;
  logic [TURN_W-1:0] prev_turns_q, prev_turns_d;
  logic [TIME_W-1:0] prev_time_q, prev_time_d;
  logic [SPD_W-1:0]  speed_q, speed_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [CRED_W-1:0] credit_q, credit_d;
  logic [POS_W-1:0]  acc_pos_q, acc_pos_d;
  logic [TURN_W-1:0] acc_turns_q, acc_turns_d;
  logic [OC_W-1:0]   outcome_q, outcome_d;
  logic              mv_q, mv_d;

  logic              ok_q;
  logic [31:0]       word_q;
  logic [TIME_W-1:0] now_q;
  dec_t              dec_q;
  logic              neg_q;
  logic [D_W-1:0]    lhs_q;
  logic [TIME_W-1:0] dt_q;
  logic [X_W-1:0]    x_q;
  logic [P_W-1:0]    p_q;
  logic [NUM_W-1:0]  num_q;
  logic [2:0]        out_user_q;
  logic [79:0]       out_data_q;

  logic [4:0]        s_eff, m_eff;
  dec_t              dec;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              div_start;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [63:0]       prod;
  logic              out_load;

  logic signed [16:0]  tdiff;
  logic                jump;
  logic signed [D_W-1:0] d0, dw;
  logic [D_W-1:0]      half_u, full_u;
  logic [D_W-1:0]      lhs_c;
  logic [TIME_W-1:0]   dt_c;
  logic [63:0]         rhs;
  logic                ovs;
  logic [8:0]          cr9;
  logic [CRED_W-1:0]   credit_next;
  logic [TALLY_W-1:0]  tally_inc;
  logic signed [SPD_W-1:0] sp;

  assign s_eff = clamp_s(cfg_s_q);
  assign m_eff = clamp_m(cfg_m_q);

  sgt_decode #(
    .WORD_BITS(WORD_BITS)
  ) u_decode (
    .word_i(word_q[WORD_BITS-1:0]),
    .s_i   (s_eff),
    .m_i   (m_eff),
    .dec_o (dec)
  );

  sgt_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    case (state_q)
      ST_MUL_A: begin
        mul_a = MUL_W'(lhs_q);
        mul_b = K_MS_PER_S;
      end
      ST_MUL_B: begin
        mul_a = dt_q;
        mul_b = MUL_W'(cfg_tps_q);
      end
      ST_MUL_C: begin
        mul_a = MUL_W'(lhs_q);
        mul_b = K_MDEG_PER_MS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  assign tdiff  = $signed({dec_q.turns[TURN_W-1], dec_q.turns})
                - $signed({prev_turns_q[TURN_W-1], prev_turns_q});
  assign jump   = (tdiff > 17'sd1) || (tdiff < -17'sd1);
  assign d0     = $signed({2'b00, dec_q.pos}) - $signed({2'b00, prev_pos_q});
  assign half_u = D_W'(1) << (s_eff - 5'd1);
  assign full_u = D_W'(1) << s_eff;
  assign dw     = (d0 > $signed(half_u))  ? d0 - $signed(full_u) :
                  (d0 < -$signed(half_u)) ? d0 + $signed(full_u) : d0;
  assign lhs_c  = dw[D_W-1] ? D_W'(-dw) : D_W'(dw);
  assign dt_c   = now_q - prev_time_q;
  assign rhs    = {24'b0, p_q} << s_eff;
  assign ovs    = {28'b0, x_q} > rhs;

  assign cr9 = ok_q ? {1'b0, credit_q} + 9'd1 :
               (credit_q != '0) ? {1'b0, credit_q} - 9'd1 : 9'd0;
  assign credit_next = (cr9 > {1'b0, cfg_cred_q}) ? cfg_cred_q : cr9[CRED_W-1:0];
  assign tally_inc   = (tally_q != '1) ? tally_q + 16'd1 : tally_q;
  assign sp = neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});

  assign div_req.start = div_start;
  assign div_req.num   = num_q;
  assign div_req.den   = {24'b0, dt_q} << s_eff;

  assign out_load = (state_q == ST_OUT) && (!mv_q || m_axis_tready);

  always_comb begin
    state_d       = state_q;
    resync_d      = resync_q;
    prev_pos_d    = prev_pos_q;
    prev_turns_d  = prev_turns_q;
    prev_time_d   = prev_time_q;
    speed_d       = speed_q;
    tally_d       = tally_q;
    credit_d      = credit_q;
    acc_pos_d     = acc_pos_q;
    acc_turns_d   = acc_turns_q;
    outcome_d     = outcome_q;
    div_start     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_DECODE;
      end
      ST_DECODE: state_d = ST_CHECK;
      ST_CHECK: begin
        credit_d = credit_next;
        state_d  = ST_OUT;
        if (!ok_q) begin
          resync_d  = 1'b1;
          outcome_d = OC_READ_FAIL;
        end else if (!dec_q.start_bit) begin
          tally_d     = tally_inc;
          resync_d    = 1'b1;
          prev_time_d = now_q;
          outcome_d   = OC_NO_START;
        end else if (resync_q) begin
          prev_pos_d   = dec_q.pos;
          prev_turns_d = dec_q.turns;
          prev_time_d  = now_q;
          resync_d     = 1'b0;
          outcome_d    = OC_RESYNC;
        end else if (jump) begin
          tally_d     = tally_inc;
          resync_d    = 1'b1;
          prev_time_d = now_q;
          outcome_d   = OC_TURN_JUMP;
        end else begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_MUL_C;
      ST_MUL_C: state_d = ST_OVS;
      ST_OVS: begin
        if ((dt_q == '0) ? (lhs_q != '0) : ovs) begin
          tally_d     = tally_inc;
          resync_d    = 1'b1;
          prev_time_d = now_q;
          outcome_d   = OC_OVERSPEED;
          state_d     = ST_OUT;
        end else if (dt_q == '0) begin
          speed_d      = '0;
          prev_pos_d   = dec_q.pos;
          prev_turns_d = dec_q.turns;
          prev_time_d  = now_q;
          acc_pos_d    = dec_q.pos;
          acc_turns_d  = dec_q.turns;
          outcome_d    = OC_UPDATED;
          state_d      = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          speed_d      = sp;
          prev_pos_d   = dec_q.pos;
          prev_turns_d = dec_q.turns;
          prev_time_d  = now_q;
          acc_pos_d    = dec_q.pos;
          acc_turns_d  = dec_q.turns;
          outcome_d    = OC_UPDATED;
          state_d      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!mv_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      mv_d = 1'b1;
    end else if (m_axis_tready) begin
      mv_d = 1'b0;
    end else begin
      mv_d = mv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_s_q    <= 5'd12;
      cfg_m_q    <= 5'd12;
      cfg_cred_q <= 8'd10;
      cfg_tps_q  <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SINGLE_TURN: cfg_s_q    <= cfg_data_i[4:0];
        REG_MULTI_TURN:  cfg_m_q    <= cfg_data_i[4:0];
        REG_MAX_CREDIT:  cfg_cred_q <= cfg_data_i;
        REG_MAX_TPS:     cfg_tps_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      resync_q     <= 1'b1;
      prev_pos_q   <= '0;
      prev_turns_q <= '0;
      prev_time_q  <= '0;
      speed_q      <= '0;
      tally_q      <= '0;
      credit_q     <= '0;
      acc_pos_q    <= '0;
      acc_turns_q  <= '0;
      outcome_q    <= OC_UPDATED;
      mv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      resync_q     <= resync_d;
      prev_pos_q   <= prev_pos_d;
      prev_turns_q <= prev_turns_d;
      prev_time_q  <= prev_time_d;
      speed_q      <= speed_d;
      tally_q      <= tally_d;
      credit_q     <= credit_d;
      acc_pos_q    <= acc_pos_d;
      acc_turns_q  <= acc_turns_d;
      outcome_q    <= outcome_d;
      mv_q         <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ok_q   <= s_axis_tuser[0];
      word_q <= s_axis_tdata[31:0];
      now_q  <= s_axis_tdata[63:32];
    end
    if (state_q == ST_DECODE) dec_q <= dec;
    if (state_q == ST_CHECK) begin
      neg_q <= dw[D_W-1];
      lhs_q <= lhs_c;
      dt_q  <= dt_c;
    end
    if (state_q == ST_MUL_A) x_q   <= prod[X_W-1:0];
    if (state_q == ST_MUL_B) p_q   <= prod[P_W-1:0];
    if (state_q == ST_MUL_C) num_q <= prod[NUM_W-1:0];
    if (out_load) begin
      out_user_q <= outcome_q;
      out_data_q <= {credit_q != '0, tally_q, speed_q, acc_turns_q, acc_pos_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_resync_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(resync_q) |-> outcome_q == OC_RESYNC)
    else $error("resync cleared without a resync outcome");

  a_tally_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q >= $past(tally_q))
    else $error("error total decreased");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && state_q == ST_DECODE)
    else $error("input still ready after an accepted beat");
`endif

endmodule
